// ===== rtl/core/thrt_pkg.sv =====
// ============================================================================
// Touch region hit test package
// Shared types, codes and sizing constants for the touch region hit test core.
// ============================================================================
package thrt_pkg;

    localparam int COORD_BITS  = 12;
    localparam int TABLE_DEPTH = 16;
    localparam int LOCKOUT_US  = 800000;
    localparam int TIME_W      = 32;
    localparam int CODE_W      = 16;
    localparam int ACT_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 3;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // Product of a sample offset and a screen span, and the divider built on it.
    localparam int PROD_W      = 2 * COORD_BITS;
    localparam int DIV_CYCLES  = PROD_W / 2;
    localparam int DIV_CNT_W   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TOUCH  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LOCKOUT = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_X_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_X_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_Y_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_Y_MAX = 3'd7;

    typedef struct packed {
        logic [CODE_W-1:0]     code;
        logic [COORD_BITS-1:0] x_lo;
        logic [COORD_BITS-1:0] y_lo;
        logic [COORD_BITS-1:0] x_hi;
        logic [COORD_BITS-1:0] y_hi;
    } region_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIX,
        S_SCAN,
        S_EMIT
    } state_t;

endpackage

// ===== rtl/core/touch_region_hit_test_core.sv =====
// ============================================================================
// Touch region hit test core
// Region table, calibrated touch scaling and first-match hit test with lockout.
// ============================================================================
// Every transaction gives exactly one result. Insert, clear, out-of-range and
// unused-action transactions are written to the result register when they are
// accepted and move on to the output register, once it is free. A touch forms
// the products, runs the two parallel dividers that retire two quotient bits per
// cycle, and then reads the N stored regions (up to 16) in table order through
// the single read port of the region memory.
// A new transaction is accepted once the previous result has been placed in
// the output register, even while that result still waits to be taken.
module touch_region_hit_test_core
    import thrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ACT_W-1:0]      action,
    input  logic [COORD_BITS-1:0] raw_x,
    input  logic [COORD_BITS-1:0] raw_y,
    input  logic [TIME_W-1:0]     time_us,
    input  logic [COORD_BITS-1:0] corner_a_x,
    input  logic [COORD_BITS-1:0] corner_a_y,
    input  logic [COORD_BITS-1:0] corner_b_x,
    input  logic [COORD_BITS-1:0] corner_b_y,
    input  logic [CODE_W-1:0]     region_code,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [CODE_W-1:0]     hit_code,
    output logic [COORD_BITS-1:0] screen_x,
    output logic [COORD_BITS-1:0] screen_y,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [COORD_BITS-1:0] raw_x_min_reg, raw_x_max_reg, raw_y_min_reg, raw_y_max_reg;
    logic [COORD_BITS-1:0] scr_x_min_reg, scr_x_max_reg, scr_y_min_reg, scr_y_max_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic              last_valid_reg, last_valid_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              chk_valid_reg, chk_valid_next;
    logic              out_valid_reg, out_valid_next;

    // Working registers of a touch.
    logic [COORD_BITS-1:0] dx_reg, dy_reg, spx_reg, spy_reg, sax_reg, say_reg;
    logic                  negx_reg, negy_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [COORD_BITS-1:0] sx_reg, sx_next, sy_reg, sy_next;

    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [CODE_W-1:0]     res_code_reg, res_code_next;
    logic [COORD_BITS-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;

    logic [STATUS_W-1:0]   out_status_reg;
    logic [CODE_W-1:0]     out_code_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;

    logic accept_in;
    logic table_full;
    logic rej_x, rej_y;
    logic load_touch;
    logic out_load;
    logic div_start;
    logic div_done_x, div_done_y;
    logic [COORD_BITS-1:0] q_x, q_y;
    logic ram_we, ram_re;
    region_t wr_entry, rd_entry;
    logic scan_hit;
    logic lockout;
    logic [TIME_W-1:0] elapsed;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept_in  = in_valid && in_ready;
    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));

    // A zero raw span is rejected along with samples outside the raw range.
    assign rej_x = (raw_x < raw_x_min_reg) || (raw_x > raw_x_max_reg) ||
                   (raw_x_max_reg == raw_x_min_reg);
    assign rej_y = (raw_y < raw_y_min_reg) || (raw_y > raw_y_max_reg) ||
                   (raw_y_max_reg == raw_y_min_reg);

    assign wr_entry.code = region_code;
    assign wr_entry.x_lo = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
    assign wr_entry.x_hi = (corner_a_x < corner_b_x) ? corner_b_x : corner_a_x;
    assign wr_entry.y_lo = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
    assign wr_entry.y_hi = (corner_a_y < corner_b_y) ? corner_b_y : corner_a_y;

    assign ram_we = accept_in && (action == ACT_INSERT) && !table_full;

    thrt_ram #(
        .WIDTH ($bits(region_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_region_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (rd_entry)
    );

    thrt_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (PROD_W'(dx_reg) * PROD_W'(sax_reg)),
        .divisor  (spx_reg),
        .done     (div_done_x),
        .quotient (q_x)
    );

    thrt_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (PROD_W'(dy_reg) * PROD_W'(say_reg)),
        .divisor  (spy_reg),
        .done     (div_done_y),
        .quotient (q_y)
    );

    assign scan_hit = (sx_reg > rd_entry.x_lo) && (sx_reg < rd_entry.x_hi) &&
                      (sy_reg > rd_entry.y_lo) && (sy_reg < rd_entry.y_hi);

    // Elapsed time wraps with the timestamp, so a plain modular difference works.
    assign elapsed = time_reg - last_time_reg;
    assign lockout = last_valid_reg && (elapsed < TIME_W'(LOCKOUT_US));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_time_next  = last_time_reg;
        last_valid_next = last_valid_reg;
        issue_next      = issue_reg;
        chk_valid_next  = chk_valid_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        res_status_next = res_status_reg;
        res_code_next   = res_code_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        load_touch      = 1'b0;
        div_start       = 1'b0;
        ram_re          = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_code_next = '0;
                    res_x_next    = '0;
                    res_y_next    = '0;
                    state_next    = S_EMIT;
                    case (action)
                        ACT_INSERT:
                        begin
                            if (table_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                res_status_next = ST_STORED;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        ACT_TOUCH:
                        begin
                            if (rej_x || rej_y)
                            begin
                                res_status_next = ST_REJECT;
                            end
                            else
                            begin
                                load_touch = 1'b1;
                                state_next = S_MUL;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            res_status_next = ST_CLEARED;
                            count_next      = '0;
                        end
                        default:
                        begin
                            res_status_next = ST_REJECT;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done_x)
                begin
                    // Truncation toward zero: scale the magnitude, then apply the sign.
                    sx_next    = negx_reg ? (scr_x_min_reg - q_x) : (scr_x_min_reg + q_x);
                    sy_next    = negy_reg ? (scr_y_min_reg - q_y) : (scr_y_min_reg + q_y);
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                if (lockout)
                begin
                    res_status_next = ST_LOCKOUT;
                    res_x_next      = sx_reg;
                    res_y_next      = sy_reg;
                    state_next      = S_EMIT;
                end
                else
                begin
                    issue_next     = '0;
                    chk_valid_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Reads are issued one per cycle; each entry is tested the cycle
                // after its read, so the first hit in table order wins.
                if (chk_valid_reg && scan_hit)
                begin
                    last_time_next  = time_reg;
                    last_valid_next = 1'b1;
                    res_status_next = ST_HIT;
                    res_code_next   = rd_entry.code;
                    res_x_next      = sx_reg;
                    res_y_next      = sy_reg;
                    chk_valid_next  = 1'b0;
                    state_next      = S_EMIT;
                end
                else if (issue_reg < count_reg)
                begin
                    ram_re         = 1'b1;
                    issue_next     = issue_reg + 1'b1;
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    res_status_next = ST_MISS;
                    res_x_next      = sx_reg;
                    res_y_next      = sy_reg;
                    chk_valid_next  = 1'b0;
                    state_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            last_time_reg  <= '0;
            last_valid_reg <= 1'b0;
            issue_reg      <= '0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            raw_x_min_reg  <= COORD_BITS'(0);
            raw_x_max_reg  <= COORD_BITS'(4095);
            raw_y_min_reg  <= COORD_BITS'(0);
            raw_y_max_reg  <= COORD_BITS'(4095);
            scr_x_min_reg  <= COORD_BITS'(0);
            scr_x_max_reg  <= COORD_BITS'(319);
            scr_y_min_reg  <= COORD_BITS'(0);
            scr_y_max_reg  <= COORD_BITS'(239);
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            last_time_reg  <= last_time_next;
            last_valid_reg <= last_valid_next;
            issue_reg      <= issue_next;
            chk_valid_reg  <= chk_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RAW_X_MIN:    raw_x_min_reg <= cfg_data;
                    CFG_RAW_X_MAX:    raw_x_max_reg <= cfg_data;
                    CFG_RAW_Y_MIN:    raw_y_min_reg <= cfg_data;
                    CFG_RAW_Y_MAX:    raw_y_max_reg <= cfg_data;
                    CFG_SCREEN_X_MIN: scr_x_min_reg <= cfg_data;
                    CFG_SCREEN_X_MAX: scr_x_max_reg <= cfg_data;
                    CFG_SCREEN_Y_MIN: scr_y_min_reg <= cfg_data;
                    CFG_SCREEN_Y_MAX: scr_y_max_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_touch)
        begin
            dx_reg   <= raw_x - raw_x_min_reg;
            dy_reg   <= raw_y - raw_y_min_reg;
            spx_reg  <= raw_x_max_reg - raw_x_min_reg;
            spy_reg  <= raw_y_max_reg - raw_y_min_reg;
            negx_reg <= (scr_x_max_reg < scr_x_min_reg);
            negy_reg <= (scr_y_max_reg < scr_y_min_reg);
            sax_reg  <= (scr_x_max_reg < scr_x_min_reg) ? (scr_x_min_reg - scr_x_max_reg)
                                                         : (scr_x_max_reg - scr_x_min_reg);
            say_reg  <= (scr_y_max_reg < scr_y_min_reg) ? (scr_y_min_reg - scr_y_max_reg)
                                                         : (scr_y_max_reg - scr_y_min_reg);
            time_reg <= time_us;
        end
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        res_status_reg <= res_status_next;
        res_code_reg   <= res_code_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_code_reg   <= res_code_reg;
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign hit_code  = out_code_reg;
    assign screen_x  = out_x_reg;
    assign screen_y  = out_y_reg;

    // Both dividers start together and run for the same number of cycles.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_done_x == div_done_y)
        else $error("X and Y dividers finished in different cycles");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("region count exceeds the table depth");

    // A tested entry must come from a read issued in the previous cycle.
    a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && chk_valid_reg) |-> $past(ram_re))
        else $error("scan tested an entry that was not read");

    a_hit_arms_lockout: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && chk_valid_reg && scan_hit) |=> last_valid_reg)
        else $error("hit did not arm the lockout");

endmodule

// ===== rtl/core/thrt_ram.sv =====
// ============================================================================
// Generic synchronous RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module thrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/thrt_div.sv =====
// ============================================================================
// Touch region hit test divider
// Iterative unsigned restoring divider, two quotient bits per cycle.
// ============================================================================
module thrt_div
    import thrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PROD_W-1:0]     dividend,
    input  logic [COORD_BITS-1:0] divisor,
    output logic                  done,
    output logic [COORD_BITS-1:0] quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [COORD_BITS-1:0] divisor_reg;
    logic [COORD_BITS-1:0] rem_reg;
    logic [PROD_W-1:0]     dq_reg;
    logic [COORD_BITS-1:0] rem_next;
    logic [PROD_W-1:0]     dq_next;

    // Two restoring steps; the remainder stays below the divisor, so it fits
    // in COORD_BITS and one extra bit covers the trial subtraction.
    always_comb
    begin
        logic [COORD_BITS:0] trial;
        rem_next = rem_reg;
        dq_next  = dq_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial   = {rem_next, dq_next[PROD_W-1]};
            dq_next = {dq_next[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial      = trial - {1'b0, divisor_reg};
                dq_next[0] = 1'b1;
            end
            rem_next = trial[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_CYCLES - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= '0;
            dq_reg      <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg[COORD_BITS-1:0];

endmodule
